// ===== rtl/core/rfill_pkg.sv =====
`timescale 1ns / 1ps
// Package for the framebuffer rectangle fill engine: widths, codes and the
// structures passed between its modules. No dependencies.
package rfill_pkg;

  localparam int COORD_BITS  = 16;
  localparam int PITCH_BITS  = 18;
  localparam int DEPTH_BITS  = 6;
  localparam int WORD_BITS   = 32;
  localparam int BYTES_BITS  = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int POFF_BITS   = COORD_BITS + BYTES_BITS;
  localparam int LBASE_BITS  = COORD_BITS + PITCH_BITS;

  localparam logic [WORD_BITS-1:0]  TEXT_BASE  = 32'h000B_8000;
  localparam logic [COORD_BITS-1:0] MIN_WIDTH  = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] MIN_HEIGHT = COORD_BITS'(200);
  localparam logic [BYTES_BITS-1:0] MAX_BYTES  = BYTES_BITS'(4);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WRITE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODEV   = 2'd1,
    ST_INVALID = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BACKEND = 3'd0,
    REG_WIDTH   = 3'd1,
    REG_HEIGHT  = 3'd2,
    REG_DEPTH   = 3'd3,
    REG_PITCH   = 3'd4,
    REG_BASE    = 3'd5,
    REG_SIZE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                  backend_present;
    logic [COORD_BITS-1:0] screen_width;
    logic [COORD_BITS-1:0] screen_height;
    logic [DEPTH_BITS-1:0] bits_per_pixel;
    logic [PITCH_BITS-1:0] line_pitch;
    logic [WORD_BITS-1:0]  frame_phys_base;
    logic [WORD_BITS-1:0]  frame_size;
  } cfg_t;

  typedef struct packed {
    logic                  operation;
    logic [COORD_BITS-1:0] rect_x;
    logic [COORD_BITS-1:0] rect_y;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
    logic [WORD_BITS-1:0]  fill_pixel;
  } item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [1:0]            status_code;
    logic [WORD_BITS-1:0]  byte_offset;
    logic [WORD_BITS-1:0]  write_data;
    logic [BYTES_BITS-1:0] write_bytes;
    logic                  last_write;
  } result_t;

endpackage

// ===== rtl/core/rfill_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the rectangle fill engine.
// Depends on rfill_pkg.
module rfill_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rfill_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rfill_pkg::WORD_BITS-1:0]      cfg_data,
  output rfill_pkg::cfg_t                      cfg
);
  import rfill_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BACKEND: cfg.backend_present <= cfg_data[0];
        REG_WIDTH:   cfg.screen_width    <= cfg_data[COORD_BITS-1:0];
        REG_HEIGHT:  cfg.screen_height   <= cfg_data[COORD_BITS-1:0];
        REG_DEPTH:   cfg.bits_per_pixel  <= cfg_data[DEPTH_BITS-1:0];
        REG_PITCH:   cfg.line_pitch      <= cfg_data[PITCH_BITS-1:0];
        REG_BASE:    cfg.frame_phys_base <= cfg_data;
        REG_SIZE:    cfg.frame_size      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/rfill_in_reg.sv =====
`timescale 1ns / 1ps
// Input register of the rectangle fill engine: holds one accepted item
// until the engine takes it. Depends on rfill_pkg.
module rfill_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rfill_pkg::item_t in_item,
  input  logic            take,
  output logic            held_valid,
  output rfill_pkg::item_t held_item
);
  import rfill_pkg::*;

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== rtl/core/rfill_engine.sv =====
`timescale 1ns / 1ps
// Fill engine: start checks, clipping and per-pixel offset walk, all between
// the input register and the result register. Depends on rfill_pkg.
module rfill_engine (
  input  logic              clk,
  input  logic              rst,
  input  rfill_pkg::cfg_t   cfg,
  input  logic              fire,
  input  rfill_pkg::item_t  item,
  output logic              has_result,
  output rfill_pkg::result_t result
);
  import rfill_pkg::*;

  logic                  fill_active;
  logic [COORD_BITS-1:0] current_row;
  logic [COORD_BITS-1:0] current_col;
  logic [COORD_BITS-1:0] first_col;
  logic [COORD_BITS:0]   end_col;
  logic [COORD_BITS:0]   end_row;
  logic [LBASE_BITS-1:0] line_base;
  logic [POFF_BITS-1:0]  pixel_offset;
  logic [POFF_BITS-1:0]  first_offset;
  logic [WORD_BITS-1:0]  held_pixel;
  logic [BYTES_BITS-1:0] pixel_bytes;

  logic                  dev_ok;
  logic [BYTES_BITS-1:0] bpp;
  logic                  do_start;
  logic [COORD_BITS:0]   x_end;
  logic [COORD_BITS:0]   y_end;
  logic [COORD_BITS:0]   col_plus;
  logic [COORD_BITS:0]   row_plus;
  logic                  last;
  logic [WORD_BITS-1:0]  mask;
  status_t               status;

  assign dev_ok = cfg.backend_present && (cfg.frame_phys_base != TEXT_BASE) &&
                  (cfg.screen_width >= MIN_WIDTH) && (cfg.screen_height >= MIN_HEIGHT) &&
                  (cfg.line_pitch != '0) && (cfg.frame_size != '0);
  assign bpp    = cfg.bits_per_pixel[DEPTH_BITS-1:3];

  always_comb begin
    do_start = 1'b0;
    if (fill_active) begin
      status = ST_BUSY;
    end else if (!dev_ok) begin
      status = ST_NODEV;
    end else if (item.rect_width == '0 || item.rect_height == '0) begin
      status = ST_OK;
    end else if (item.rect_x >= cfg.screen_width || item.rect_y >= cfg.screen_height) begin
      status = ST_INVALID;
    end else if (bpp == '0 || bpp > MAX_BYTES) begin
      status = ST_INVALID;
    end else begin
      status   = ST_OK;
      do_start = 1'b1;
    end
  end

  always_comb begin
    x_end = {1'b0, item.rect_x} + {1'b0, item.rect_width};
    if (x_end > {1'b0, cfg.screen_width}) begin
      x_end = {1'b0, cfg.screen_width};
    end
    y_end = {1'b0, item.rect_y} + {1'b0, item.rect_height};
    if (y_end > {1'b0, cfg.screen_height}) begin
      y_end = {1'b0, cfg.screen_height};
    end
  end

  assign col_plus = {1'b0, current_col} + 1'b1;
  assign row_plus = {1'b0, current_row} + 1'b1;
  assign last     = (col_plus >= end_col) && (row_plus >= end_row);

  always_comb begin
    case (pixel_bytes)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  always_comb begin
    result = '0;
    if (item.operation == OP_START) begin
      has_result         = 1'b1;
      result.result_kind = KIND_STATUS;
      result.status_code = status;
    end else begin
      has_result         = fill_active;
      result.result_kind = KIND_WRITE;
      result.status_code = ST_OK;
      result.byte_offset = line_base[WORD_BITS-1:0] + WORD_BITS'(pixel_offset);
      result.write_data  = held_pixel & mask;
      result.write_bytes = pixel_bytes;
      result.last_write  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_active  <= 1'b0;
      current_row  <= '0;
      current_col  <= '0;
      first_col    <= '0;
      end_col      <= '0;
      end_row      <= '0;
      line_base    <= '0;
      pixel_offset <= '0;
      first_offset <= '0;
      held_pixel   <= '0;
      pixel_bytes  <= '0;
    end else if (fire) begin
      if (item.operation == OP_START) begin
        if (do_start) begin
          fill_active  <= 1'b1;
          first_col    <= item.rect_x;
          current_col  <= item.rect_x;
          current_row  <= item.rect_y;
          end_col      <= x_end;
          end_row      <= y_end;
          pixel_bytes  <= bpp;
          pixel_offset <= POFF_BITS'(item.rect_x) * POFF_BITS'(bpp);
          first_offset <= POFF_BITS'(item.rect_x) * POFF_BITS'(bpp);
          line_base    <= LBASE_BITS'(item.rect_y) * LBASE_BITS'(cfg.line_pitch);
          held_pixel   <= item.fill_pixel;
        end
      end else if (fill_active) begin
        if (last) begin
          fill_active <= 1'b0;
        end else if (col_plus >= end_col) begin
          // Wrap to the left edge of the next row.
          current_col  <= first_col;
          pixel_offset <= first_offset;
          current_row  <= row_plus[COORD_BITS-1:0];
          line_base    <= line_base + LBASE_BITS'(cfg.line_pitch);
        end else begin
          current_col  <= col_plus[COORD_BITS-1:0];
          pixel_offset <= pixel_offset + POFF_BITS'(pixel_bytes);
        end
      end
    end
  end

endmodule

// ===== rtl/core/rfill_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the rectangle fill engine, facing the output channel.
// Depends on rfill_pkg.
module rfill_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               load_valid,
  input  rfill_pkg::result_t load_data,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output rfill_pkg::result_t out_data
);
  import rfill_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== rtl/core/framebuffer_rect_fill.sv =====
`timescale 1ns / 1ps
// Solid rectangle fill engine for a linear framebuffer, top level.
// Depends on rfill_pkg, rfill_cfg_regs, rfill_in_reg, rfill_engine, rfill_out_reg.
//
// A start transfer (operation 0) checks the programmed geometry and the
// rectangle, clips the rectangle to the screen and always answers with one
// status transfer: ok, no device, invalid, or busy when a fill is already
// running. Once a fill is running, every step transfer (operation 1) yields
// exactly one pixel write transfer carrying the byte offset
// row * line_pitch + col * pixel_bytes (kept to 32 bits), the pixel word
// cut to its low bytes, the byte count and a last mark on the final pixel;
// pixels go row by row, left to right. A step while no fill runs produces
// nothing. Each item passes through an input register and combinational logic
// into the result register, so the block takes one item per clock while the
// output is not stalled. The result register is loaded from the held item
// whenever it is free, and the result transfer takes place once the output
// is not stalled. The start multiply (top row times line pitch) is the longest
// path; later offsets advance by additions only. Configuration registers are
// written through the plain write port (indexes beyond the last register
// are ignored) and should only change while no item is in flight; the line
// pitch is read again whenever the fill moves to a new row.
module framebuffer_rect_fill (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rfill_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rfill_pkg::WORD_BITS-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [rfill_pkg::COORD_BITS-1:0]    rect_x,
  input  logic [rfill_pkg::COORD_BITS-1:0]    rect_y,
  input  logic [rfill_pkg::COORD_BITS-1:0]    rect_width,
  input  logic [rfill_pkg::COORD_BITS-1:0]    rect_height,
  input  logic [rfill_pkg::WORD_BITS-1:0]     fill_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic [1:0]                          status_code,
  output logic [rfill_pkg::WORD_BITS-1:0]     byte_offset,
  output logic [rfill_pkg::WORD_BITS-1:0]     write_data,
  output logic [rfill_pkg::BYTES_BITS-1:0]    write_bytes,
  output logic                                last_write
);
  import rfill_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    fire;
  logic    has_result;
  result_t result;
  result_t out_data;

  assign in_item.operation   = operation;
  assign in_item.rect_x      = rect_x;
  assign in_item.rect_y      = rect_y;
  assign in_item.rect_width  = rect_width;
  assign in_item.rect_height = rect_height;
  assign in_item.fill_pixel  = fill_pixel;

  // The held item is processed whenever the result register can take its
  // answer; an item with no answer still needs the slot to be free so that
  // ordering against the result register stays simple.
  assign fire = held_valid && out_free;

  rfill_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfill_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rfill_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .item       (held_item),
    .has_result (has_result),
    .result     (result)
  );

  rfill_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_valid (has_result),
    .load_data  (result),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign result_kind = out_data.result_kind;
  assign status_code = out_data.status_code;
  assign byte_offset = out_data.byte_offset;
  assign write_data  = out_data.write_data;
  assign write_bytes = out_data.write_bytes;
  assign last_write  = out_data.last_write;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for framebuffer_rect_fill: a directed table, then random fill traffic.
// Every result transfer is compared with an in-bench model of the fill engine.
// Depends on rfill_pkg and the framebuffer_rect_fill RTL.
module tb_top;
  import rfill_pkg::*;

  // Cycles allowed after the last expected result before the registers may change.
  // A step taken while no fill runs yields nothing but still travels through the
  // two register stages, so a few cycles cover it.
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEM_TARGET     = 1800;
  localparam int PHASE_ITEMS     = 150;
  // No register lives at this index; a write to it must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG_INDEX = 3'd7;

  typedef struct {
    int      preset;
    item_t   stim;
    bit      pinned;
    status_t pinned_status;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]   cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   operation;
  logic [COORD_BITS-1:0]  rect_x;
  logic [COORD_BITS-1:0]  rect_y;
  logic [COORD_BITS-1:0]  rect_width;
  logic [COORD_BITS-1:0]  rect_height;
  logic [WORD_BITS-1:0]   fill_pixel;
  logic                   out_valid;
  logic                   out_stall;
  logic                   result_kind;
  logic [1:0]             status_code;
  logic [WORD_BITS-1:0]   byte_offset;
  logic [WORD_BITS-1:0]   write_data;
  logic [BYTES_BITS-1:0]  write_bytes;
  logic                   last_write;

  framebuffer_rect_fill dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .rect_x(rect_x), .rect_y(rect_y),
    .rect_width(rect_width), .rect_height(rect_height), .fill_pixel(fill_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .status_code(status_code), .byte_offset(byte_offset),
    .write_data(write_data), .write_bytes(write_bytes), .last_write(last_write)
  );

  always #1 clk = ~clk;

  // Results still owed by the block, oldest first.
  result_t awaited_results[$];
  int      mismatch_count = 0;
  int      served = 0;          // accepted transfers that owe a result
  int      cycle_count = 0;
  bit      steady_traffic = 1'b0;
  bit      hold_off_req = 1'b0;

  // Shadow of the geometry registers and of the fill in progress.
  cfg_t                  geom = '0;
  bit                    fill_on = 1'b0;
  logic [COORD_BITS-1:0] row_now = '0;
  logic [COORD_BITS-1:0] col_now = '0;
  logic [COORD_BITS-1:0] col_first = '0;
  logic [COORD_BITS:0]   col_end = '0;
  logic [COORD_BITS:0]   row_end = '0;
  logic [LBASE_BITS-1:0] line_addr = '0;
  logic [POFF_BITS-1:0]  pix_addr = '0;
  logic [WORD_BITS-1:0]  pixel_word = '0;
  logic [BYTES_BITS-1:0] bytes_pp = '0;

  function automatic bit device_ready();
    return geom.backend_present && geom.frame_phys_base != TEXT_BASE &&
           geom.screen_width >= MIN_WIDTH && geom.screen_height >= MIN_HEIGHT &&
           geom.line_pitch != '0 && geom.frame_size != '0;
  endfunction

  // Works out the result of one accepted transfer and advances the shadow fill.
  // Returns 0 when the transfer yields nothing (a step with no fill running).
  function automatic bit predict_fill(input item_t it, output result_t res);
    logic [BYTES_BITS-1:0] depth_bytes;
    logic [COORD_BITS:0]   right;
    logic [COORD_BITS:0]   bottom;
    logic [WORD_BITS-1:0]  mask;
    bit                    final_px;
    res = '0;
    if (it.operation == OP_START) begin
      res.result_kind = KIND_STATUS;
      depth_bytes = BYTES_BITS'(geom.bits_per_pixel >> 3);
      if (fill_on) begin
        res.status_code = ST_BUSY;
      end else if (!device_ready()) begin
        res.status_code = ST_NODEV;
      end else if (it.rect_width == '0 || it.rect_height == '0) begin
        res.status_code = ST_OK;
      end else if (it.rect_x >= geom.screen_width || it.rect_y >= geom.screen_height) begin
        res.status_code = ST_INVALID;
      end else if (depth_bytes == '0 || depth_bytes > MAX_BYTES) begin
        res.status_code = ST_INVALID;
      end else begin
        // The far edges are summed one bit wider so that they never wrap.
        right = 17'(it.rect_x) + 17'(it.rect_width);
        if (right > 17'(geom.screen_width)) right = 17'(geom.screen_width);
        bottom = 17'(it.rect_y) + 17'(it.rect_height);
        if (bottom > 17'(geom.screen_height)) bottom = 17'(geom.screen_height);
        fill_on    = 1'b1;
        col_first  = it.rect_x;
        col_now    = it.rect_x;
        row_now    = it.rect_y;
        col_end    = right;
        row_end    = bottom;
        bytes_pp   = depth_bytes;
        pix_addr   = POFF_BITS'(it.rect_x) * POFF_BITS'(depth_bytes);
        line_addr  = LBASE_BITS'(it.rect_y) * LBASE_BITS'(geom.line_pitch);
        pixel_word = it.fill_pixel;
        res.status_code = ST_OK;
      end
      return 1'b1;
    end
    if (!fill_on) return 1'b0;
    mask = (bytes_pp >= MAX_BYTES) ? '1 : 32'((64'd1 << (8 * bytes_pp)) - 64'd1);
    final_px = (17'(col_now) + 17'd1 >= col_end) && (17'(row_now) + 17'd1 >= row_end);
    res.result_kind = KIND_WRITE;
    res.status_code = ST_OK;
    res.byte_offset = 32'(line_addr + LBASE_BITS'(pix_addr));
    res.write_data  = pixel_word & mask;
    res.write_bytes = bytes_pp;
    res.last_write  = final_px;
    if (final_px) begin
      fill_on = 1'b0;
    end else begin
      col_now  = col_now + 1'b1;
      pix_addr = pix_addr + POFF_BITS'(bytes_pp);
      if (17'(col_now) >= col_end) begin
        // Next row: the pitch is taken from the register as it stands now.
        col_now   = col_first;
        pix_addr  = POFF_BITS'(col_first) * POFF_BITS'(bytes_pp);
        row_now   = row_now + 1'b1;
        line_addr = line_addr + LBASE_BITS'(geom.line_pitch);
      end
    end
    return 1'b1;
  endfunction

  function automatic int pixels_left();
    if (!fill_on) return 0;
    return int'(col_end - 17'(col_now)) +
           int'(row_end - 17'(row_now) - 17'd1) * int'(col_end - 17'(col_first));
  endfunction

  function automatic item_t make_item(op_t op, int x, int y, int w, int h,
                                      logic [WORD_BITS-1:0] pix);
    item_t it;
    it.operation   = op;
    it.rect_x      = COORD_BITS'(x);
    it.rect_y      = COORD_BITS'(y);
    it.rect_width  = COORD_BITS'(w);
    it.rect_height = COORD_BITS'(h);
    it.fill_pixel  = pix;
    return it;
  endfunction

  function automatic item_t random_item(op_t op);
    item_t it;
    it = make_item(op, $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
    // A stray start must not open a fill so large that the phase never drains.
    if (op == OP_START && !fill_on) begin
      it.rect_width  = COORD_BITS'($urandom_range(0, 3));
      it.rect_height = COORD_BITS'($urandom_range(0, 3));
    end
    return it;
  endfunction

  function automatic probe_row_t probe(int preset, op_t op, int x, int y, int w, int h,
                                       logic [WORD_BITS-1:0] pix, bit pinned,
                                       status_t st);
    probe_row_t row;
    row.preset        = preset;
    row.stim          = make_item(op, x, y, w, h, pix);
    row.pinned        = pinned;
    row.pinned_status = st;
    return row;
  endfunction

  function automatic cfg_t make_geometry(bit present, int w, int h, int bits, int pitch,
                                         logic [WORD_BITS-1:0] base,
                                         logic [WORD_BITS-1:0] size);
    cfg_t g;
    g.backend_present = present;
    g.screen_width    = COORD_BITS'(w);
    g.screen_height   = COORD_BITS'(h);
    g.bits_per_pixel  = DEPTH_BITS'(bits);
    g.line_pitch      = PITCH_BITS'(pitch);
    g.frame_phys_base = base;
    g.frame_size      = size;
    return g;
  endfunction

  // Mostly just above the minimum, sometimes the largest value, below the
  // minimum or anything at all.
  function automatic int pick_span(int floor_px);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return floor_px + $urandom_range(0, 64);
    if (r < 80) return 65535;
    if (r < 85) return $urandom_range(0, floor_px - 1);
    return $urandom_range(0, 65535);
  endfunction

  function automatic cfg_t random_geometry(int phase);
    cfg_t g;
    int   r;
    if (phase == 0)
      return make_geometry(1'b1, MIN_WIDTH, MIN_HEIGHT, 8, int'(MIN_WIDTH), $urandom(),
                           $urandom_range(1, 65535));
    if (phase == 1)
      return make_geometry(1'b1, 65535, 65535, 32, 262143, '1, '1);
    g.backend_present = ($urandom_range(0, 19) != 0);
    g.screen_width    = COORD_BITS'(pick_span(MIN_WIDTH));
    g.screen_height   = COORD_BITS'(pick_span(MIN_HEIGHT));
    r = $urandom_range(0, 99);
    g.bits_per_pixel = (r < 60) ? DEPTH_BITS'(8 * $urandom_range(1, 4) + $urandom_range(0, 7))
                                : DEPTH_BITS'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < 10) g.line_pitch = '1;
    else if (r < 15) g.line_pitch = '0;
    else if (r < 40) g.line_pitch = PITCH_BITS'($urandom_range(1, 64));
    else g.line_pitch = PITCH_BITS'($urandom_range(1, 262143));
    g.frame_phys_base = ($urandom_range(0, 99) < 5) ? TEXT_BASE : $urandom();
    r = $urandom_range(0, 99);
    g.frame_size = (r < 5) ? '0 : (r < 10) ? '1 : $urandom();
    return g;
  endfunction

  function automatic int pick_origin(int limit);
    int r;
    r = $urandom_range(0, 99);
    if (limit == 0) return $urandom_range(0, 65535);
    if (r < 10) return limit - 1;
    if (r < 20) return 0;
    if (r < 25) return limit;
    if (r < 28) return $urandom_range(limit, 65535);
    return $urandom_range(0, limit - 1);
  endfunction

  // Large extents only where clipping keeps the fill to a few pixels.
  function automatic int pick_extent(int origin, int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 30 && origin < limit && limit - origin <= 4)
      return $urandom_range(limit - origin, 65535);
    return $urandom_range(1, 5);
  endfunction

  function automatic void check_field(string label, logic [WORD_BITS-1:0] want,
                                      logic [WORD_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after
  // its transfer. Valid stays high into the next item unless a gap is drawn.
  task automatic send_item(input item_t it, input bit pinned = 1'b0,
                           input status_t pinned_status = ST_OK);
    result_t res;
    bit      produces;
    if (!steady_traffic && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= it.operation;
    rect_x      <= it.rect_x;
    rect_y      <= it.rect_y;
    rect_width  <= it.rect_width;
    rect_height <= it.rect_height;
    fill_pixel  <= it.fill_pixel;
    do @(posedge clk); while (in_stall);
    produces = predict_fill(it, res);
    if (produces) begin
      if (pinned) begin
        res = '0;
        res.result_kind = KIND_STATUS;
        res.status_code = pinned_status;
      end
      awaited_results.push_back(res);
      served++;
    end
    @(negedge clk);
  endtask

  // Stops offering items until every owed result has arrived, then lets
  // extra_cycles pass so that an ignored step still in flight is gone.
  task automatic settle_block(input int extra_cycles);
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
    repeat (extra_cycles) @(negedge clk);
  endtask

  // Writes every register, with junk above each register's width, then one
  // write to the unused index. Only called with the block idle.
  task automatic program_geometry(input cfg_t g);
    logic [WORD_BITS-1:0] value;
    logic [WORD_BITS-1:0] keep;
    reg_idx_t             idx;
    for (int i = REG_BACKEND; i <= REG_SIZE; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_BACKEND: begin value = 32'(g.backend_present); keep = 32'h0000_0001; end
        REG_WIDTH:   begin value = 32'(g.screen_width);    keep = 32'h0000_FFFF; end
        REG_HEIGHT:  begin value = 32'(g.screen_height);   keep = 32'h0000_FFFF; end
        REG_DEPTH:   begin value = 32'(g.bits_per_pixel);  keep = 32'h0000_003F; end
        REG_PITCH:   begin value = 32'(g.line_pitch);      keep = 32'h0003_FFFF; end
        REG_BASE:    begin value = g.frame_phys_base;      keep = '1;            end
        default:     begin value = g.frame_size;           keep = '1;            end
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value | ($urandom() & ~keep);
      @(negedge clk);
    end
    cfg_index <= SPARE_REG_INDEX;
    cfg_data  <= $urandom();
    @(negedge clk);
    cfg_we <= 1'b0;
    geom = g;
  endtask

  // One start with a rectangle drawn around the screen edges, followed by its
  // steps; now and then a stray item, a fill overrun or a fill left open.
  task automatic run_fill_sequence();
    int x, y, w, h, left, steps;
    if ($urandom_range(0, 99) < 10) begin
      send_item(random_item(op_t'($urandom_range(0, 1))));
      return;
    end
    x = pick_origin(geom.screen_width);
    y = pick_origin(geom.screen_height);
    w = pick_extent(x, geom.screen_width);
    h = pick_extent(y, geom.screen_height);
    send_item(make_item(OP_START, x, y, w, h, $urandom()));
    left = pixels_left();
    case ($urandom_range(0, 9))
      0: steps = left + $urandom_range(1, 2);
      1: steps = (left > 0) ? $urandom_range(0, left - 1) : 0;
      default: steps = left;
    endcase
    repeat (steps) send_item(random_item(OP_STEP));
  endtask

  // Result side: compares each transfer with the oldest owed result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d status %0d offset %h data %h",
                 $time, result_kind, status_code, byte_offset, write_data);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_kind));
        check_field("status_code", 32'(want.status_code), 32'(status_code));
        check_field("byte_offset", want.byte_offset, byte_offset);
        check_field("write_data", want.write_data, write_data);
        check_field("write_bytes", 32'(want.write_bytes), 32'(write_bytes));
        check_field("last_write", 32'(want.last_write), 32'(last_write));
      end
    end
  end

  // Receiver: stalls at random about one cycle in ten, never during the steady
  // phase, and once holds off for a long run of cycles so that the block backs
  // up and stalls its input.
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !steady_traffic && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL framebuffer_rect_fill");
      $finish;
    end
  end

  initial begin : stimulus
    probe_row_t rows[$];
    cfg_t       presets[11];
    int         preset_now;
    int         phase;
    int         phase_end;
    int         random_base;
    bit         paused;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    operation   = 1'b0;
    rect_x      = '0;
    rect_y      = '0;
    rect_width  = '0;
    rect_height = '0;
    fill_pixel  = '0;

    // Geometry presets for the directed table; preset 0 is the state after reset.
    presets[0] = '0;
    presets[1] = make_geometry(1'b1, 320, 200, 32, 1280, 32'hE000_0000, 32'h0003_E800);
    presets[2] = presets[1];
    presets[2].frame_phys_base = TEXT_BASE;
    presets[3] = presets[1];
    presets[3].screen_width = MIN_WIDTH - 1'b1;
    presets[4] = presets[1];
    presets[4].screen_height = MIN_HEIGHT - 1'b1;
    presets[5] = presets[1];
    presets[5].line_pitch = '0;
    presets[6] = presets[1];
    presets[6].frame_size = '0;
    presets[7] = presets[1];
    presets[7].bits_per_pixel = DEPTH_BITS'(7);
    presets[8] = presets[1];
    presets[8].bits_per_pixel = '1;
    presets[9]  = make_geometry(1'b1, 65535, 65535, 39, 262143, '1, '1);
    presets[10] = make_geometry(1'b1, 320, 200, 8, 1, '0, 32'd1);

    // Directed table. Status answers that follow straight from the checks are
    // pinned here; pixel writes come from the shadow model.
    rows.push_back(probe(0, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(0, OP_STEP, 0, 0, 0, 0, 32'h0, 0, ST_OK));
    rows.push_back(probe(1, OP_START, 0, 0, 0, 5, 32'h1, 1, ST_OK));
    rows.push_back(probe(1, OP_START, 5, 5, 3, 0, 32'h1, 1, ST_OK));
    rows.push_back(probe(1, OP_START, 320, 0, 1, 1, 32'h1, 1, ST_INVALID));
    rows.push_back(probe(1, OP_START, 0, 200, 1, 1, 32'h1, 1, ST_INVALID));
    rows.push_back(probe(1, OP_START, 318, 198, 4, 3, 32'hA5A5_1234, 1, ST_OK));
    rows.push_back(probe(1, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_BUSY));
    repeat (4) rows.push_back(probe(1, OP_STEP, 0, 0, 0, 0, 32'h0, 0, ST_OK));
    rows.push_back(probe(1, OP_STEP, 0, 0, 0, 0, 32'h0, 0, ST_OK));
    rows.push_back(probe(2, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(3, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(4, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(5, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(6, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_NODEV));
    rows.push_back(probe(7, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_INVALID));
    rows.push_back(probe(8, OP_START, 0, 0, 1, 1, 32'h0, 1, ST_INVALID));
    // Far corner of the largest screen: the edge sums exceed 16 bits and the
    // byte offset runs past 32 bits.
    rows.push_back(probe(9, OP_START, 65534, 65534, 65535, 65535, '1, 1, ST_OK));
    rows.push_back(probe(9, OP_STEP, 0, 0, 0, 0, 32'h0, 0, ST_OK));
    rows.push_back(probe(10, OP_START, 0, 0, 2, 1, 32'h1234_5678, 1, ST_OK));
    repeat (2) rows.push_back(probe(10, OP_STEP, 0, 0, 0, 0, 32'h0, 0, ST_OK));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    preset_now = 0;
    foreach (rows[i]) begin
      if (rows[i].preset != preset_now) begin
        settle_block(SETTLE_CYCLES);
        program_geometry(presets[rows[i].preset]);
        preset_now = rows[i].preset;
      end
      send_item(rows[i].stim, rows[i].pinned, rows[i].pinned_status);
    end

    // Random phases, each with its own geometry. Phase 2 runs without any
    // idling, phase 3 starts with the long receiver hold-off and phase 5 has
    // the sender wait halfway for every owed result.
    random_base = served;
    phase = 0;
    paused = 1'b0;
    while (served - random_base < ITEM_TARGET) begin
      settle_block(SETTLE_CYCLES);
      program_geometry(random_geometry(phase));
      steady_traffic = (phase == 2);
      if (phase == 3) hold_off_req = 1'b1;
      phase_end = served + PHASE_ITEMS;
      while (served < phase_end) begin
        run_fill_sequence();
        if (phase == 5 && !paused && served >= phase_end - PHASE_ITEMS / 2) begin
          settle_block(0);
          paused = 1'b1;
        end
      end
      // Close any open fill so the next geometry starts from an idle engine.
      repeat (pixels_left()) send_item(random_item(OP_STEP));
      phase++;
    end
    steady_traffic = 1'b0;

    settle_block(SETTLE_CYCLES);
    if (mismatch_count == 0) $display("PASS framebuffer_rect_fill");
    else $display("FAIL framebuffer_rect_fill");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rfill_pkg.sv
rtl/core/rfill_cfg_regs.sv
rtl/core/rfill_in_reg.sv
rtl/core/rfill_engine.sv
rtl/core/rfill_out_reg.sv
rtl/core/framebuffer_rect_fill.sv
bench/tb_top.sv
